// ===== src/htd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants for the code tree decoder: result kinds,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package htd_pkg;

	localparam int NODE_COUNT_DEF    = 512;
	localparam int MAX_CODE_BITS_DEF = 20;
	localparam int CODE_BITS         = 20;
	localparam int BYTE_BITS         = 8;
	localparam int SYM_BITS          = 8;

	typedef enum logic [1:0] {
		KIND_SYMBOL       = 2'd0,
		KIND_PREFIX_ERROR = 2'd1,
		KIND_INSERT_DONE  = 2'd2,
		KIND_TABLE_FULL   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_INS,
		ST_FIN,
		ST_DEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic  load;
		logic  rd;
		logic  adv;
		logic  alloc;
		logic  wr_leaf;
		logic  wr_zero;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
		logic  to_root;
		logic  save_cur;
		logic  clr_cur;
		logic  stash;
		logic  use_pend;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_dec;
		logic cnt_zero;
		logic child_zero;
		logic node_vld;
		logic table_full;
		logic out_free;
		logic in_empty;
		logic pend_vld;
	} stat_t;

endpackage

// ===== src/htd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_ctrl
// Controller state machine: sequences the table reads, tree steps, node
// allocation, leaf writes and result emission for one item at a time.
// ----------------------------------------------------------------------------
module htd_ctrl import htd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.emit_kind = KIND_SYMBOL;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// empty insert or zero-bit decode: drop the item
					if (!stat.in_empty) state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.rd = 1'b1;
				if (stat.op_dec) begin
					state_d = ST_DEC;
				end else if (stat.cnt_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (!stat.child_zero) begin
					cmd.adv = 1'b1;
					state_d = ST_LOOK;
				end else if (!stat.table_full) begin
					cmd.alloc = 1'b1;
					state_d   = ST_LOOK;
				end else if (stat.out_free) begin
					cmd.wr_zero   = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_TABLE_FULL;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.wr_leaf   = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_INSERT_DONE;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_DEC: begin
				if (stat.node_vld) begin
					if (stat.pend_vld) begin
						// another result follows the held symbol: release it
						if (stat.out_free) begin
							cmd.emit      = 1'b1;
							cmd.use_pend  = 1'b1;
							cmd.emit_kind = KIND_SYMBOL;
						end
					end else if (stat.cnt_zero) begin
						// symbol on the last bit: final item of the byte
						if (stat.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_SYMBOL;
							cmd.emit_last = 1'b1;
							cmd.to_root   = 1'b1;
							cmd.clr_cur   = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						// symbol mid byte: hold it and restart at the root
						cmd.stash   = 1'b1;
						cmd.to_root = 1'b1;
						state_d     = ST_LOOK;
					end
				end else if (stat.cnt_zero) begin
					// byte used up: keep the position, held symbol is the last item
					if (stat.pend_vld) begin
						if (stat.out_free) begin
							cmd.emit      = 1'b1;
							cmd.use_pend  = 1'b1;
							cmd.emit_kind = KIND_SYMBOL;
							cmd.emit_last = 1'b1;
							cmd.save_cur  = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						cmd.save_cur = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (stat.child_zero) begin
					if (stat.out_free) begin
						if (stat.pend_vld) begin
							cmd.emit      = 1'b1;
							cmd.use_pend  = 1'b1;
							cmd.emit_kind = KIND_SYMBOL;
						end else begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_PREFIX_ERROR;
							cmd.emit_last = 1'b1;
							cmd.clr_cur   = 1'b1;
							state_d       = ST_IDLE;
						end
					end
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_LOOK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/htd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_datapath
// Node table memory, walk registers, bit shifter, allocation pointer and
// the result output register.
// ----------------------------------------------------------------------------
module htd_datapath import htd_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic                  op,
	input  logic [CODE_BITS-1:0]  code_bits,
	input  logic [4:0]            code_length,
	input  logic [SYM_BITS-1:0]   symbol_in,
	input  logic [BYTE_BITS-1:0]  data_byte,
	input  logic [3:0]            valid_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [SYM_BITS-1:0]   symbol,
	output logic                  last
);

	localparam int IW     = $clog2(NODE_COUNT);
	localparam int EW     = 2 * IW + SYM_BITS + 1;
	localparam int VLD_B  = SYM_BITS;
	localparam int C0_LSB = SYM_BITS + 1;
	localparam int C1_LSB = C0_LSB + IW;
	localparam int SW     = (MAX_CODE_BITS > CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
	localparam int LW     = $clog2(MAX_CODE_BITS + 1);

	logic [EW-1:0]     mem [NODE_COUNT];
	logic [EW-1:0]     rd_q;
	logic              blank_q;
	logic              fresh_q;
	logic              root_init_q;
	logic              moved_q;
	logic              pend_vld_q;
	logic [SYM_BITS-1:0] pend_sym_q;
	logic [IW-1:0]     node_q;
	logic [IW-1:0]     cur_node_q;
	logic [IW:0]       next_free_q;
	logic [SW-1:0]     sh_q;
	logic [LW-1:0]     cnt_q;
	logic [SYM_BITS-1:0] sym_q;
	logic              op_q;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [SYM_BITS-1:0] symbol_q;
	logic              last_q;

	logic [EW-1:0]     ent;
	logic [IW-1:0]     c0, c1, child;
	logic              bit_now;
	logic [LW-1:0]     ld_len;
	logic [SW-1:0]     ld_sh;
	logic              we;
	logic [EW-1:0]     wd;
	logic              out_free;

	// current entry; fresh or never-written root reads as cleared
	assign ent     = (fresh_q || blank_q) ? '0 : rd_q;
	assign c0      = ent[C0_LSB +: IW];
	assign c1      = ent[C1_LSB +: IW];
	assign bit_now = sh_q[SW-1];
	assign child   = bit_now ? c1 : c0;
	assign out_free = !out_valid_q || out_ready;

	// status to the controller; a node counts as reached only after a step
	always_comb begin
		stat.op_dec     = op_q;
		stat.cnt_zero   = (cnt_q == '0);
		stat.child_zero = (child == '0);
		stat.node_vld   = moved_q && ent[VLD_B];
		stat.table_full = (next_free_q == (IW+1)'(NODE_COUNT));
		stat.out_free   = out_free;
		stat.in_empty   = op ? (valid_bits == 4'd0) : (code_length == 5'd0);
		stat.pend_vld   = pend_vld_q;
	end

	// load: saturate length and left-align the bits to walk
	always_comb begin
		if (op) begin
			ld_len = (valid_bits > 4'(BYTE_BITS)) ? LW'(BYTE_BITS) : LW'(valid_bits);
			ld_sh  = SW'(data_byte) << (SW - int'(ld_len));
		end else begin
			ld_len = (32'(code_length) > MAX_CODE_BITS) ? LW'(MAX_CODE_BITS)
			                                            : LW'(code_length);
			ld_sh  = SW'(code_bits) << (SW - int'(ld_len));
		end
	end

	// table write port
	always_comb begin
		we = 1'b0;
		wd = ent;
		if (cmd.alloc) begin
			we = 1'b1;
			if (bit_now) begin
				wd[C1_LSB +: IW] = next_free_q[IW-1:0];
			end else begin
				wd[C0_LSB +: IW] = next_free_q[IW-1:0];
			end
		end else if (cmd.wr_leaf) begin
			we = 1'b1;
			wd[VLD_B]      = 1'b1;
			wd[SYM_BITS-1:0] = sym_q;
		end else if (cmd.wr_zero && fresh_q) begin
			we = 1'b1;
			wd = '0;
		end
	end

	// node table
	always_ff @(posedge clk) begin
		if (we) mem[node_q] <= wd;
		if (cmd.rd) rd_q <= mem[node_q];
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			sym_q  <= symbol_in;
			sh_q   <= ld_sh;
			cnt_q  <= ld_len;
			node_q <= op ? cur_node_q : '0;
		end else if (cmd.adv) begin
			sh_q   <= {sh_q[SW-2:0], 1'b0};
			cnt_q  <= cnt_q - LW'(1);
			node_q <= child;
		end else if (cmd.alloc) begin
			sh_q   <= {sh_q[SW-2:0], 1'b0};
			cnt_q  <= cnt_q - LW'(1);
			node_q <= next_free_q[IW-1:0];
		end else if (cmd.to_root) begin
			node_q <= '0;
		end
		// held symbol waits for the next result or the end of the byte
		if (cmd.stash) pend_sym_q <= ent[SYM_BITS-1:0];
	end

	// walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q     <= 1'b0;
			blank_q     <= 1'b0;
			root_init_q <= 1'b0;
			moved_q     <= 1'b0;
			pend_vld_q  <= 1'b0;
			next_free_q <= (IW+1)'(1);
			cur_node_q  <= '0;
		end else begin
			if (cmd.load || cmd.adv || cmd.to_root) begin
				fresh_q <= 1'b0;
			end else if (cmd.alloc) begin
				fresh_q <= 1'b1;
			end
			if (cmd.adv) begin
				moved_q <= 1'b1;
			end else if (cmd.load || cmd.to_root) begin
				moved_q <= 1'b0;
			end
			if (cmd.stash) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.use_pend) begin
				pend_vld_q <= 1'b0;
			end
			if (cmd.rd) blank_q <= (node_q == '0) && !root_init_q;
			if (we && node_q == '0) root_init_q <= 1'b1;
			if (cmd.alloc) next_free_q <= next_free_q + (IW+1)'(1);
			if (cmd.clr_cur) begin
				cur_node_q <= '0;
			end else if (cmd.save_cur) begin
				cur_node_q <= node_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.emit_kind;
			if (cmd.use_pend) begin
				symbol_q <= pend_sym_q;
			end else begin
				symbol_q <= (cmd.emit_kind == KIND_SYMBOL) ? ent[SYM_BITS-1:0] : '0;
			end
			last_q   <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

endmodule

// ===== src/huffman_trie_decoder_top.sv =====
`timescale 1ns / 1ps
// An insert walks its code bits from the root, each a table read and then a step or a new
// node, and ends with the leaf write. A decode walks its bits the same way, plus a root
// reread and the release of the held item for each symbol finished before the last bit;
// a prefix error ends it early. The block takes one item at a time, on a single-port node
// table with registered read. Stalls on out_ready hold the walk.
// Reset (arst_n low): walk at the root, one node in use, table reads as empty, no clearing.
// ----------------------------------------------------------------------------
// huffman_trie_decoder_top
// Code tree decoder: builds a binary code tree from insert items and walks
// it with decode bytes, emitting symbols, prefix errors and insert status.
// ----------------------------------------------------------------------------
module huffman_trie_decoder_top import htd_pkg::*; #(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [CODE_BITS-1:0] code_bits,
	input  logic [4:0]           code_length,
	input  logic [SYM_BITS-1:0]  symbol_in,
	input  logic [BYTE_BITS-1:0] data_byte,
	input  logic [3:0]           valid_bits,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           kind,
	output logic [SYM_BITS-1:0]  symbol,
	output logic                 last
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	htd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table and walk datapath
	htd_datapath #(
		.NODE_COUNT    (NODE_COUNT),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.code_bits   (code_bits),
		.code_length (code_length),
		.symbol_in   (symbol_in),
		.data_byte   (data_byte),
		.valid_bits  (valid_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.symbol      (symbol),
		.last        (last)
	);

endmodule
